### rtl/ttyop_pkg.sv
// Shared types, character codes and per-character effect functions for the
// terminal output post-processor. No dependencies.
package ttyop_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [6:0] char7_t;

  // Character codes
  localparam char7_t EOF_CHAR   = 7'h04;
  localparam char7_t CH_BS      = 7'h08;
  localparam char7_t CH_HT      = 7'h09;
  localparam char7_t CH_LF      = 7'h0A;
  localparam char7_t CH_VT      = 7'h0B;
  localparam char7_t CH_FF      = 7'h0C;
  localparam char7_t CH_CR      = 7'h0D;
  localparam char7_t CH_SPACE   = 7'h20;
  localparam char7_t CH_BANG    = 7'h21;
  localparam char7_t CH_QUOTE   = 7'h27;
  localparam char7_t CH_LPAREN  = 7'h28;
  localparam char7_t CH_RPAREN  = 7'h29;
  localparam char7_t CH_BSLASH  = 7'h5C;
  localparam char7_t CH_CARET   = 7'h5E;
  localparam char7_t CH_GRAVE   = 7'h60;
  localparam char7_t CH_LOWER_A = 7'h61;
  localparam char7_t CH_LOWER_Z = 7'h7A;
  localparam char7_t CH_LBRACE  = 7'h7B;
  localparam char7_t CH_VBAR    = 7'h7C;
  localparam char7_t CH_RBRACE  = 7'h7D;
  localparam char7_t CH_TILDE   = 7'h7E;
  localparam char7_t CASE_OFFSET = 7'h20;

  // Delay byte marker and tick counts
  localparam byte_t  DLY_FLAG     = 8'h80;
  localparam char7_t DLY_NL_MIN   = 7'd6;
  localparam char7_t DLY_NL_BIAS  = 7'd3;
  localparam char7_t DLY_CR_SHORT = 7'd5;
  localparam char7_t DLY_CR_LONG  = 7'd10;
  localparam char7_t DLY_VERT     = 7'd127;
  localparam char7_t DLY_TAB_BASE = 7'd9;
  localparam char7_t DLY_TAB_MIN  = 7'd5;

  // Delay mode codes
  localparam logic [1:0] NL_DLY_COLUMN  = 2'd1;
  localparam logic [1:0] NL_DLY_FIXED   = 2'd2;
  localparam logic [1:0] CR_DLY_SHORT   = 2'd1;
  localparam logic [1:0] CR_DLY_LONG    = 2'd2;
  localparam logic [1:0] TAB_DLY_COLUMN = 2'd1;

  typedef enum logic [2:0] {
    CFG_POST_PROCESS,
    CFG_EXPAND_TABS,
    CFG_UPPER_ONLY,
    CFG_NL_RETURN,
    CFG_NL_DELAY,
    CFG_CR_DELAY,
    CFG_TAB_DELAY,
    CFG_VERT_DELAY
  } cfg_idx_e;

  typedef struct packed {
    logic       post_process;
    logic       expand_tabs;
    logic       upper_only;
    logic       nl_return;
    logic [1:0] nl_dly;
    logic [1:0] cr_dly;
    logic [1:0] tab_dly;
    logic       vert_dly;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    post_process: 1'b1, expand_tabs: 1'b0, upper_only: 1'b0, nl_return: 1'b1,
    nl_dly: 2'd0, cr_dly: 2'd0, tab_dly: 2'd0, vert_dly: 1'b0
  };

  // One classified request from the front to the back
  typedef struct packed {
    logic   raw;      // pass ch unchanged
    logic   tabx;     // expand tab to spaces
    logic   has_pre;  // emit pre before ch
    char7_t pre;
    byte_t  ch;
  } cmd_t;

  typedef enum logic [2:0] {
    SEQ_START,
    SEQ_PRE_DLY,
    SEQ_MAIN,
    SEQ_MAIN_DLY,
    SEQ_TAB
  } seq_state_e;

  typedef struct packed {
    byte_t  col;
    char7_t dly;  // zero: no delay byte
  } fx_t;

  // Upper-case-only mapping: bit 7 flags a backslash escape.
  function automatic byte_t upper_map(char7_t c);
    logic   esc;
    char7_t m;
    esc = 1'b1;
    m   = c;
    unique case (c)
      CH_LBRACE: m = CH_LPAREN;
      CH_RBRACE: m = CH_RPAREN;
      CH_VBAR:   m = CH_BANG;
      CH_TILDE:  m = CH_CARET;
      CH_GRAVE:  m = CH_QUOTE;
      default:   esc = 1'b0;
    endcase
    if (m >= CH_LOWER_A && m <= CH_LOWER_Z) begin
      m = m - CASE_OFFSET;
    end
    return {esc, m};
  endfunction

  // Column update and delay for one emitted character.
  function automatic fx_t char_effect(char7_t c, byte_t col, cfg_t cfg);
    fx_t    r;
    char7_t nl;
    char7_t td;
    r.col = col;
    r.dly = '0;
    nl    = {3'b000, col[7:4]} + DLY_NL_BIAS;
    td    = DLY_TAB_BASE - {4'b0000, col[2:0]};
    unique case (c)
      CH_BS: begin
        if (col != '0) r.col = col - 8'd1;
      end
      CH_LF: begin
        if (cfg.nl_dly == NL_DLY_COLUMN) begin
          r.dly = (col != '0 && nl > DLY_NL_MIN) ? nl : DLY_NL_MIN;
        end else if (cfg.nl_dly == NL_DLY_FIXED) begin
          r.dly = DLY_NL_MIN;
        end
        r.col = '0;
      end
      CH_HT: begin
        if (cfg.tab_dly == TAB_DLY_COLUMN && td >= DLY_TAB_MIN) r.dly = td;
        r.col = {col[7:3] + 5'd1, 3'b000};
      end
      CH_VT, CH_FF: begin
        if (cfg.vert_dly) r.dly = DLY_VERT;
      end
      CH_CR: begin
        if (cfg.cr_dly == CR_DLY_SHORT) begin
          r.dly = DLY_CR_SHORT;
        end else if (cfg.cr_dly == CR_DLY_LONG) begin
          r.dly = DLY_CR_LONG;
        end
        r.col = '0;
      end
      default: begin
        if (c >= CH_SPACE && c <= CH_TILDE) r.col = col + 8'd1;
      end
    endcase
    return r;
  endfunction

endpackage

### rtl/ttyop_cfg.sv
// Configuration register bank of the terminal output post-processor.
// Depends on ttyop_pkg.
module ttyop_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [1:0]          cfg_data_i,
  output ttyop_pkg::cfg_t     cfg_o
);
  import ttyop_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_POST_PROCESS: cfg_d.post_process = cfg_data_i[0];
        CFG_EXPAND_TABS:  cfg_d.expand_tabs  = cfg_data_i[0];
        CFG_UPPER_ONLY:   cfg_d.upper_only   = cfg_data_i[0];
        CFG_NL_RETURN:    cfg_d.nl_return    = cfg_data_i[0];
        CFG_NL_DELAY:     cfg_d.nl_dly       = cfg_data_i;
        CFG_CR_DELAY:     cfg_d.cr_dly       = cfg_data_i;
        CFG_TAB_DELAY:    cfg_d.tab_dly      = cfg_data_i;
        CFG_VERT_DELAY:   cfg_d.vert_dly     = cfg_data_i[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/ttyop_front.sv
// Front end: classifies incoming characters into requests for the back end
// and holds them in a two-entry request queue. Depends on ttyop_pkg.
module ttyop_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ttyop_pkg::cfg_t   cfg_i,
  input  logic              push_i,
  output logic              full_o,
  input  logic [7:0]        char_in_i,
  output logic              cmd_valid_o,
  output ttyop_pkg::cmd_t   cmd_o,
  input  logic              cmd_pop_i
);
  import ttyop_pkg::*;

  cmd_t       q_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_new;
  char7_t     c7;
  byte_t      um;
  logic       esc;
  char7_t     mapped;
  logic       drop, acc, enq, deq;

  always_comb begin
    c7     = char_in_i[6:0];
    um     = upper_map(c7);
    esc    = cfg_i.upper_only && um[7];
    mapped = cfg_i.upper_only ? um[6:0] : c7;
    drop   = cfg_i.post_process && (c7 == EOF_CHAR);

    cmd_new.raw     = !cfg_i.post_process;
    cmd_new.tabx    = cfg_i.post_process && cfg_i.expand_tabs && (c7 == CH_HT);
    cmd_new.has_pre = cfg_i.post_process && !cmd_new.tabx &&
                      (esc || (mapped == CH_LF && cfg_i.nl_return));
    cmd_new.pre     = esc ? CH_BSLASH : CH_CR;
    cmd_new.ch      = cfg_i.post_process ? {1'b0, mapped} : char_in_i;
  end

  assign full_o      = (cnt_q == 2'd2);
  assign acc         = push_i && !full_o;
  // With processing on, EOF is accepted and dropped here
  assign enq         = acc && !drop;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign deq         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (enq) wr_ptr_q <= !wr_ptr_q;
      if (deq) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) q_q[wr_ptr_q] <= cmd_new;
  end

endmodule

### rtl/ttyop_back.sv
// Back end: sequences each request into output bytes, tracks the print
// column and buffers results in a two-entry output queue. Depends on ttyop_pkg.
module ttyop_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ttyop_pkg::cfg_t   cfg_i,
  input  logic              cmd_valid_i,
  input  ttyop_pkg::cmd_t   cmd_i,
  output logic              cmd_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [7:0]        byte_out_o,
  output logic              last_of_run_o
);
  import ttyop_pkg::*;

  seq_state_e state_q, state_d;
  byte_t      column_q, column_d;
  char7_t     delay_q, delay_d;
  char7_t     fx_ch;
  fx_t        fx;
  byte_t      ob;
  logic       ol, done, fire;
  logic       do_main, do_tab;

  byte_t      obyte_q [2];
  logic       olast_q [2];
  logic       owr_q, ord_q;
  logic [1:0] ocnt_q;
  logic       ofull, odeq;

  assign ofull = (ocnt_q == 2'd2);
  assign fire  = cmd_valid_i && !ofull;

  always_comb begin
    if (state_q == SEQ_TAB || (state_q == SEQ_START && cmd_i.tabx)) begin
      fx_ch = CH_SPACE;
    end else if (state_q == SEQ_START && cmd_i.has_pre) begin
      fx_ch = cmd_i.pre;
    end else begin
      fx_ch = cmd_i.ch[6:0];
    end
    fx = char_effect(fx_ch, column_q, cfg_i);

    state_d  = state_q;
    column_d = column_q;
    delay_d  = delay_q;
    ob       = '0;
    ol       = 1'b0;
    done     = 1'b0;
    do_main  = 1'b0;
    do_tab   = 1'b0;

    unique case (state_q)
      SEQ_START: begin
        if (cmd_i.raw) begin
          ob   = cmd_i.ch;
          ol   = 1'b1;
          done = 1'b1;
        end else if (cmd_i.tabx) begin
          do_tab = 1'b1;
        end else if (cmd_i.has_pre) begin
          ob       = {1'b0, cmd_i.pre};
          column_d = fx.col;
          delay_d  = fx.dly;
          state_d  = (fx.dly != '0) ? SEQ_PRE_DLY : SEQ_MAIN;
        end else begin
          do_main = 1'b1;
        end
      end
      SEQ_PRE_DLY: begin
        ob      = DLY_FLAG | {1'b0, delay_q};
        state_d = SEQ_MAIN;
      end
      SEQ_MAIN:     do_main = 1'b1;
      SEQ_MAIN_DLY: begin
        ob   = DLY_FLAG | {1'b0, delay_q};
        ol   = 1'b1;
        done = 1'b1;
      end
      SEQ_TAB:      do_tab = 1'b1;
      default:      state_d = SEQ_START;
    endcase

    if (do_main) begin
      ob       = {1'b0, cmd_i.ch[6:0]};
      column_d = fx.col;
      delay_d  = fx.dly;
      if (fx.dly != '0) begin
        state_d = SEQ_MAIN_DLY;
      end else begin
        ol   = 1'b1;
        done = 1'b1;
      end
    end

    if (do_tab) begin
      ob       = {1'b0, CH_SPACE};
      column_d = fx.col;
      // stop on the next multiple of eight
      if (fx.col[2:0] == 3'd0) begin
        ol   = 1'b1;
        done = 1'b1;
      end else begin
        state_d = SEQ_TAB;
      end
    end

    if (done) state_d = SEQ_START;
  end

  assign cmd_pop_o = fire && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SEQ_START;
      column_q <= '0;
    end else if (fire) begin
      state_q  <= state_d;
      column_q <= column_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) delay_q <= delay_d;
  end

  // Output queue
  assign empty_o       = (ocnt_q == 2'd0);
  assign odeq          = pop_i && !empty_o;
  assign byte_out_o    = obyte_q[ord_q];
  assign last_of_run_o = olast_q[ord_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (fire) owr_q <= !owr_q;
      if (odeq) ord_q <= !ord_q;
      ocnt_q <= ocnt_q + {1'b0, fire} - {1'b0, odeq};
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      obyte_q[owr_q] <= ob;
      olast_q[owr_q] <= ol;
    end
  end

endmodule

### rtl/tty_output_postprocessor.sv
// Terminal output post-processor top level: config bank, front classifier
// and back sequencer. Depends on ttyop_pkg, ttyop_cfg, ttyop_front, ttyop_back.
//
// Usage:
//   Input channel: drive char_in_i and raise push; the character is taken at
//   an edge where full is low. Output channel: while empty is low the oldest
//   byte is on byte_out_o with last_of_run_o marking the final byte caused by
//   one character; raise pop to take it.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i at a clock
//   edge; write only while no character is in flight.
//   Flow: a character is registered in the request queue, then in the
//   output queue. Ordinary characters sustain one byte per cycle while the
//   output queue has room. A character that expands (escape, carriage return,
//   delay byte, tab spaces) holds the back-end sequencer for up to eight bytes.
//   EOF (004) with processing on is accepted and gives no output.
//   Reset: clears the column, both queues and loads the default settings.
//   A stalled receiver fills the two-entry output queue, then the two-entry
//   request queue, after which full rises and input is held off.
module tty_output_postprocessor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [1:0] cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] byte_out_o,
  output logic       last_of_run_o
);
  import ttyop_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  ttyop_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ttyop_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .push_i      (push),
    .full_o      (full),
    .char_in_i   (char_in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  ttyop_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .byte_out_o    (byte_out_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

### rtl/ttyop_checker.sv
// Port-level checker for the terminal output post-processor, bound to the
// top level. Depends on tty_output_postprocessor.
module ttyop_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] byte_out_o,
  input logic       last_of_run_o
);

  // a waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(byte_out_o) && $stable(last_of_run_o)))
    else $error("result changed while waiting");

  // a full request queue always has work headed to the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |=> !empty)
    else $error("full without pending result");

  assert property (@(posedge clk_i) !rst_ni |=> (empty && !full))
    else $error("queues not clear in reset");

  // with nothing waiting at the output, the request queue fills only right after a push
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && !$past(push)) |-> !full)
    else $error("full while nothing pending");

endmodule

bind tty_output_postprocessor ttyop_checker u_ttyop_checker (.*);
